### rtl/hsb_pkg.sv
// ----------------------------------------------------------------------------
// hsb_pkg: shared types and constants of the bucketed hash set
// Geometry, command codes, memory row layout and stream widths.
// ----------------------------------------------------------------------------
package hsb_pkg;

  // Geometry. Buckets must be a power of two: the bucket is the low key bits.
  localparam int Buckets = 1024;
  localparam int Ways    = 4;
  localparam int KeyW    = 20;
  localparam int CmdW    = 2;
  localparam int BucketW = $clog2(Buckets);

  // Stream payload widths, rounded up to whole bytes.
  localparam int InFieldsW  = CmdW + KeyW;
  localparam int OutFieldsW = 2;
  localparam int STdataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int MTdataW    = ((OutFieldsW + 7) / 8) * 8;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  // One memory row holds a whole bucket.
  typedef struct packed {
    logic [Ways-1:0]           valid;
    logic [Ways-1:0][KeyW-1:0] keys;
  } row_t;

  localparam int RowW = $bits(row_t);

  // Result of one bucket lookup.
  typedef struct packed {
    logic found;
    logic status;
  } match_t;

endpackage

### rtl/hash_set_bucketed_unit.sv
// ----------------------------------------------------------------------------
// hash_set_bucketed_unit: bounded hash set of 20-bit keys
// Add, remove and membership query over buckets of a few ways each.
// ----------------------------------------------------------------------------
// Each input transaction carries a command (add, remove, query) and a key and
// yields exactly one result transaction: found (key was present before the
// command) and status (1 when an add was dropped because its bucket is full).
// The bucket is the low bits of the key. A whole bucket (all ways with their
// valid marks) is one row of a single synchronous RAM. The accept cycle issues
// the row read; the lookup state then compares, updates and writes the row
// back and loads the result register. Because the write-back lands before the
// next read is issued, consecutive commands to the same bucket need no
// forwarding. After reset a clearing pass writes empty rows to all Buckets
// rows before the first input transaction is accepted. A result waiting at
// the output does not block accepting the next input; the lookup stage holds
// until the result register is free. A new input is accepted only after the
// previous write-back.
// ----------------------------------------------------------------------------
module hash_set_bucketed_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // slave side
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [hsb_pkg::STdataW-1:0]  s_axis_tdata,   // [1:0] cmd, [21:2] key
  // master side
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [hsb_pkg::MTdataW-1:0]  m_axis_tdata    // [0] found, [1] status
);

  hsb_pkg::state_e state_q, state_d;

  logic [hsb_pkg::BucketW-1:0] clr_cnt_q, clr_cnt_d;
  logic [hsb_pkg::CmdW-1:0]    cmd_q;
  logic [hsb_pkg::KeyW-1:0]    key_q;
  logic                        out_valid_q, out_valid_d;
  logic                        found_q;
  logic                        status_q;

  logic                        in_fire;
  logic                        out_free;
  logic                        out_load;
  logic                        clr_done;

  logic                        ram_we;
  logic [hsb_pkg::BucketW-1:0] ram_waddr;
  hsb_pkg::row_t               ram_wdata;
  hsb_pkg::row_t               ram_rdata;
  hsb_pkg::row_t               upd_row;
  hsb_pkg::match_t             match;

  logic [hsb_pkg::CmdW-1:0]    in_cmd;
  logic [hsb_pkg::KeyW-1:0]    in_key;

  assign in_cmd = s_axis_tdata[hsb_pkg::CmdW-1:0];
  assign in_key = s_axis_tdata[hsb_pkg::CmdW +: hsb_pkg::KeyW];

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign clr_done = (clr_cnt_q == hsb_pkg::BucketW'(hsb_pkg::Buckets - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hsb_pkg::ST_CLEAR:  if (clr_done) state_d = hsb_pkg::ST_IDLE;
      hsb_pkg::ST_IDLE:   if (in_fire) state_d = hsb_pkg::ST_LOOKUP;
      hsb_pkg::ST_LOOKUP: if (out_free) state_d = hsb_pkg::ST_IDLE;
      default:            state_d = hsb_pkg::ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      hsb_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      hsb_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      hsb_pkg::ST_LOOKUP: begin
        ram_we   = out_free;
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // Clearing pass writes empty rows; lookup writes the updated bucket back.
  assign ram_waddr = (state_q == hsb_pkg::ST_CLEAR) ? clr_cnt_q
                                                    : key_q[hsb_pkg::BucketW-1:0];
  assign ram_wdata = (state_q == hsb_pkg::ST_CLEAR) ? hsb_pkg::row_t'('0) : upd_row;

  assign clr_cnt_d = (state_q == hsb_pkg::ST_CLEAR) ? clr_cnt_q + 1'b1 : clr_cnt_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hsb_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= in_cmd;
      key_q <= in_key;
    end
    if (out_load) begin
      found_q  <= match.found;
      status_q <= match.status;
    end
  end

  hsb_ram #(
    .Width (hsb_pkg::RowW),
    .Depth (hsb_pkg::Buckets)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (in_key[hsb_pkg::BucketW-1:0]),
    .rdata_o (ram_rdata)
  );

  hsb_match u_match (
    .row_i   (ram_rdata),
    .cmd_i   (cmd_q),
    .key_i   (key_q),
    .row_o   (upd_row),
    .match_o (match)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(hsb_pkg::MTdataW - hsb_pkg::OutFieldsW)'(0), status_q, found_q};

endmodule

### rtl/hsb_ram.sv
// ----------------------------------------------------------------------------
// hsb_ram: simple dual-port synchronous RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hsb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/hsb_match.sv
// ----------------------------------------------------------------------------
// hsb_match: bucket compare and update
// Finds the key among the valid ways, picks the lowest free way, and builds
// the row to write back for the command.
// ----------------------------------------------------------------------------
module hsb_match (
  input  hsb_pkg::row_t                  row_i,
  input  logic [hsb_pkg::CmdW-1:0]       cmd_i,
  input  logic [hsb_pkg::KeyW-1:0]       key_i,
  output hsb_pkg::row_t                  row_o,
  output hsb_pkg::match_t                match_o
);

  logic [hsb_pkg::Ways-1:0] hit_oh;
  logic [hsb_pkg::Ways-1:0] free_oh;
  logic                     hit;
  logic                     have_free;

  // Lowest matching way and lowest free way, as one-hot masks.
  always_comb begin
    hit       = 1'b0;
    have_free = 1'b0;
    hit_oh    = '0;
    free_oh   = '0;
    for (int w = 0; w < hsb_pkg::Ways; w++) begin
      if (row_i.valid[w] && (row_i.keys[w] == key_i) && !hit) begin
        hit       = 1'b1;
        hit_oh[w] = 1'b1;
      end else if (!row_i.valid[w] && !have_free) begin
        have_free  = 1'b1;
        free_oh[w] = 1'b1;
      end
    end
  end

  always_comb begin
    row_o          = row_i;
    match_o.found  = hit;
    match_o.status = 1'b0;
    unique case (hsb_pkg::cmd_e'(cmd_i))
      hsb_pkg::CMD_ADD: begin
        if (!hit) begin
          if (have_free) begin
            for (int w = 0; w < hsb_pkg::Ways; w++) begin
              if (free_oh[w]) begin
                row_o.keys[w]  = key_i;
                row_o.valid[w] = 1'b1;
              end
            end
          end else begin
            match_o.status = 1'b1;  // bucket full, add dropped
          end
        end
      end
      hsb_pkg::CMD_REMOVE: begin
        row_o.valid = row_i.valid & ~hit_oh;
      end
      default: begin
        // query; the unused code acts as a query too
      end
    endcase
  end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for hash_set_bucketed_unit
// Sends add, remove and query commands and checks each result transaction
// against a shadow copy of the bucket table. A directed sequence covers the
// corner cases: empty set, duplicate add, full bucket, absent remove, the
// unused command code and keys at the top of the range. Random traffic then
// runs in four flow-control phases. Most random keys come from a small pool
// of keys that share a few buckets, so buckets fill up, drop adds and churn.
// ----------------------------------------------------------------------------
module tb;

  localparam int ClkPeriod    = 20;
  localparam int ResetCycles  = 10;
  localparam int RandPerPhase = 250;
  localparam int MaxReports   = 10;
  localparam int HotBuckets   = 8;
  localparam int HotTags      = 6;
  localparam int TagMax       = (1 << hsb_pkg::KeyW) / hsb_pkg::Buckets - 1;
  localparam int DrainCycles  = 20;

  // The command code with no meaning; the block treats it as a query.
  localparam logic [hsb_pkg::CmdW-1:0] CmdUnused = 2'd3;

  typedef struct packed {
    logic [hsb_pkg::KeyW-1:0] key;
    logic [hsb_pkg::CmdW-1:0] cmd;
  } hs_cmd_t;

  typedef struct packed {
    logic found;
    logic status;
  } hs_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [hsb_pkg::STdataW-1:0] s_axis_tdata = '0;   // [1:0] cmd, [21:2] key
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [hsb_pkg::MTdataW-1:0] m_axis_tdata;        // [0] found, [1] status

  hash_set_bucketed_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow bucket table: what the set should hold at any time.
  logic [hsb_pkg::KeyW-1:0] shadow_key   [hsb_pkg::Buckets][hsb_pkg::Ways];
  logic                     shadow_valid [hsb_pkg::Buckets][hsb_pkg::Ways];

  hs_cmd_t   cmd_backlog[$];       // commands not yet presented
  hs_reply_t replies_due[$];       // predicted results, oldest first

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_added = 0;
  int n_dropped = 0;
  int n_removed = 0;
  int n_hits = 0;

  int hot_bucket [HotBuckets];
  int hot_tag    [HotTags];

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Append a command at the tail of the backlog.
  function automatic void queue_cmd(hs_cmd_t c);
    cmd_backlog.insert(cmd_backlog.size(), c);
  endfunction

  // Apply one command to the shadow table and queue the result it produces.
  function automatic void apply_hash_cmd(hs_cmd_t c);
    int        b;
    int        hit_way;
    int        free_way;
    hs_reply_t r;
    b        = int'(c.key) % hsb_pkg::Buckets;
    hit_way  = -1;
    free_way = -1;
    r        = '0;
    for (int w = 0; w < hsb_pkg::Ways; w++) begin
      if (shadow_valid[b][w]) begin
        if (hit_way < 0 && shadow_key[b][w] == c.key) hit_way = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    if (c.cmd == hsb_pkg::CMD_ADD && hit_way < 0) begin
      if (free_way >= 0) begin
        shadow_key[b][free_way]   = c.key;
        shadow_valid[b][free_way] = 1'b1;
        n_added++;
      end else begin
        r.status = 1'b1;
        n_dropped++;
      end
    end else if (c.cmd == hsb_pkg::CMD_REMOVE && hit_way >= 0) begin
      shadow_valid[b][hit_way] = 1'b0;
      n_removed++;
    end
    r.found = (hit_way >= 0);
    if (r.found) n_hits++;
    replies_due.insert(replies_due.size(), r);
  endfunction

  function automatic hs_cmd_t mk_cmd(logic [hsb_pkg::CmdW-1:0] cmd, int key);
    hs_cmd_t c;
    c.cmd = cmd;
    c.key = key[hsb_pkg::KeyW-1:0];
    return c;
  endfunction

  // Random command: mostly keys from a hot pool that crowds a few buckets,
  // the rest anywhere in the 20-bit key space.
  function automatic hs_cmd_t rand_cmd();
    int                       r;
    int                       key;
    logic [hsb_pkg::CmdW-1:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 40)      cmd = hsb_pkg::CMD_ADD;
    else if (r < 65) cmd = hsb_pkg::CMD_REMOVE;
    else if (r < 92) cmd = hsb_pkg::CMD_QUERY;
    else             cmd = CmdUnused;
    if ($urandom_range(0, 99) < 80)
      key = hot_tag[$urandom_range(0, HotTags - 1)] * hsb_pkg::Buckets
          + hot_bucket[$urandom_range(0, HotBuckets - 1)];
    else
      key = $urandom_range(0, (1 << hsb_pkg::KeyW) - 1);
    return mk_cmd(cmd, key);
  endfunction

  // Driver: predict on each accepted command, then present the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_hash_cmd(mk_cmd(s_axis_tdata[hsb_pkg::CmdW-1:0],
                              int'(s_axis_tdata[hsb_pkg::CmdW +: hsb_pkg::KeyW])));
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= hsb_pkg::STdataW'(cmd_backlog.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and in-order compare of results.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (replies_due.size() == 0) begin
          n_errors++;
          if (n_errors <= MaxReports)
            $display("ERROR: unexpected result found=%0b status=%0b",
                     m_axis_tdata[0], m_axis_tdata[1]);
        end else begin
          hs_reply_t want;
          want = replies_due.pop_front();
          n_checked++;
          if (m_axis_tdata[0] !== want.found || m_axis_tdata[1] !== want.status) begin
            n_errors++;
            if (n_errors <= MaxReports)
              $display("ERROR: result %0d: expected found=%0b status=%0b, %s%0b status=%0b",
                       n_checked, want.found, want.status, "got found=",
                       m_axis_tdata[0], m_axis_tdata[1]);
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Waits until everything queued has been sent and every result returned.
  task automatic drain();
    while (cmd_backlog.size() > 0 || s_axis_tvalid || replies_due.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < RandPerPhase; i++) queue_cmd(rand_cmd());
    drain();
  endtask

  initial begin
    int kb;
    for (int b = 0; b < hsb_pkg::Buckets; b++)
      for (int w = 0; w < hsb_pkg::Ways; w++) begin
        shadow_key[b][w]   = '0;
        shadow_valid[b][w] = 1'b0;
      end
    for (int i = 0; i < HotBuckets; i++)
      hot_bucket[i] = $urandom_range(0, hsb_pkg::Buckets - 1);
    for (int i = 0; i < HotTags; i++)
      hot_tag[i] = $urandom_range(0, TagMax);

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Bucket kb gets four keys, then a fifth that is dropped.
    kb = 5;
    queue_cmd(mk_cmd(hsb_pkg::CMD_ADD,    0));
    queue_cmd(mk_cmd(hsb_pkg::CMD_QUERY,  0));
    queue_cmd(mk_cmd(hsb_pkg::CMD_ADD,    0));                       // duplicate add
    queue_cmd(mk_cmd(hsb_pkg::CMD_ADD,    (1 << hsb_pkg::KeyW) - 1));
    queue_cmd(mk_cmd(CmdUnused,           (1 << hsb_pkg::KeyW) - 1));
    queue_cmd(mk_cmd(hsb_pkg::CMD_REMOVE, (1 << hsb_pkg::KeyW) - 1));
    queue_cmd(mk_cmd(hsb_pkg::CMD_REMOVE, (1 << hsb_pkg::KeyW) - 1)); // now absent
    queue_cmd(mk_cmd(hsb_pkg::CMD_QUERY,  (1 << hsb_pkg::KeyW) - 1));
    for (int w = 0; w < hsb_pkg::Ways; w++)
      queue_cmd(mk_cmd(hsb_pkg::CMD_ADD, kb + w * hsb_pkg::Buckets));
    // bucket full
    queue_cmd(mk_cmd(hsb_pkg::CMD_ADD,    kb + hsb_pkg::Ways * hsb_pkg::Buckets));
    queue_cmd(mk_cmd(hsb_pkg::CMD_QUERY,  kb + hsb_pkg::Ways * hsb_pkg::Buckets));
    queue_cmd(mk_cmd(hsb_pkg::CMD_REMOVE, kb + hsb_pkg::Buckets));
    // reuses freed way
    queue_cmd(mk_cmd(hsb_pkg::CMD_ADD,    kb + hsb_pkg::Ways * hsb_pkg::Buckets));
    queue_cmd(mk_cmd(hsb_pkg::CMD_ADD,    kb + hsb_pkg::Ways * hsb_pkg::Buckets));
    queue_cmd(mk_cmd(hsb_pkg::CMD_QUERY,  kb + hsb_pkg::Buckets));
    queue_cmd(mk_cmd(CmdUnused,           1000001));
    queue_cmd(mk_cmd(hsb_pkg::CMD_REMOVE, 0));
    drain();

    // Random traffic under each flow-control mix.
    run_phase(0, 0);
    run_phase(86, 0);
    run_phase(0, 86);
    run_phase(16, 16);

    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d commands, %0d results checked: %0d adds stored, %0d dropped full,",
             n_sent, n_checked, n_added, n_dropped);
    $display("%0d removes hit, %0d commands found their key; %0d mismatches.",
             n_removed, n_hits, n_errors);
    if (n_errors == 0 && replies_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run including the clearing pass.
  initial begin
    #(ClkPeriod * 200_000);
    $display("ERROR: timeout with %0d results outstanding", replies_due.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/hsb_pkg.sv
rtl/hsb_ram.sv
rtl/hsb_match.sv
rtl/hash_set_bucketed_unit.sv
bench/tb.sv
